>>> rtl/lpps_pkg.sv
// Shared types, widths, register codes and tables of the leg pair pose smoother.
package lpps_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MEAN_SEP_DEF   = 300;
	localparam int SIGMA_INIT_DEF = 50;

	localparam int FIELD_W    = 16;
	localparam int COORD_W    = 17;
	localparam int DIFF_W     = 18;
	localparam int TC_W       = 10;
	localparam int SEP_W      = 16;
	localparam int ANG_W      = 16;
	localparam int LEFT_W     = 40;
	localparam int MUL_W      = 20;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DIV_W      = 42;
	localparam int RAD_W      = 38;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int CORD_W     = 29;
	localparam int CORD_STEPS = 14;
	localparam int CORD_PRE   = 8;
	localparam int CFG_IDX_W  = 3;

	localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;
	localparam logic [ANG_W-1:0] HALF_TURN    = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_TC  = 3'd0,
		REG_FACE_TC  = 3'd1,
		REG_SEP_TC   = 3'd2,
		REG_SIGMA_TC = 3'd3,
		REG_MIN_SEP  = 3'd4,
		REG_MAX_SEP  = 3'd5,
		REG_SEP_EN   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] leg_a_x;
		logic signed [FIELD_W-1:0] leg_a_y;
		logic signed [FIELD_W-1:0] leg_b_x;
		logic signed [FIELD_W-1:0] leg_b_y;
		logic signed [FIELD_W-1:0] vel_x;
		logic signed [FIELD_W-1:0] vel_y;
		logic                      leg_a_seen;
		logic                      leg_b_seen;
	} in_item_t;

	typedef struct packed {
		logic signed [LEFT_W-1:0] leftness_out;
		logic signed [ANG_W-1:0]  facing_out;
		logic [SEP_W-1:0]         sep_mean_out;
		logic [SEP_W-1:0]         sep_sigma_out;
	} out_item_t;

	// atan(2^-i) in binary-angle units
	function automatic logic [ANG_W-1:0] atan_step(input logic [3:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			4'd0:    a = 16'd8192;
			4'd1:    a = 16'd4836;
			4'd2:    a = 16'd2555;
			4'd3:    a = 16'd1297;
			4'd4:    a = 16'd651;
			4'd5:    a = 16'd326;
			4'd6:    a = 16'd163;
			4'd7:    a = 16'd81;
			4'd8:    a = 16'd41;
			4'd9:    a = 16'd20;
			4'd10:   a = 16'd10;
			4'd11:   a = 16'd5;
			4'd12:   a = 16'd3;
			4'd13:   a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

	// field bits read as a cb-bit coordinate: sign extended up to 16 bits, zero extended above
	function automatic logic signed [COORD_W-1:0] coord_ext(input logic [FIELD_W-1:0] raw,
		input int cb);
		logic sgn;
		logic [COORD_W-1:0] v;
		sgn = (cb <= FIELD_W) ? raw[cb-1] : 1'b0;
		for (int i = 0; i < FIELD_W; i++) begin
			v[i] = (i < cb) ? raw[i] : sgn;
		end
		v[COORD_W-1] = sgn;
		return $signed(v);
	endfunction

endpackage

>>> rtl/lpps_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module lpps_mul #(
	parameter int W = lpps_pkg::MUL_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic                  done,
	output logic signed [2*W-1:0] p
);
	localparam int CNT_W = $clog2(W + 1);

	logic [2*W-1:0] mcand_q;
	logic [2*W-1:0] acc_q;
	logic [W-1:0]   mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic           neg_q;
	logic           busy_q;
	logic           done_q;
	logic [W-1:0]   mag_a, mag_b;

	assign mag_a = a[W-1] ? W'(-a) : W'(a);
	assign mag_b = b[W-1] ? W'(-b) : W'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{W{1'b0}}, mag_a};
			mplier_q <= mag_b;
			acc_q    <= '0;
			neg_q    <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[2*W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = neg_q ? -$signed(acc_q) : $signed(acc_q);
endmodule

>>> rtl/lpps_div.sv
// Bit-serial restoring divider, signed numerator by unsigned divisor, truncating toward zero.
module lpps_div #(
	parameter int NW = lpps_pkg::DIV_W,
	parameter int DW = lpps_pkg::TC_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic                 done,
	output logic signed [NW-1:0] quo
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    nm_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             ge;
	logic [DW:0]      diff;

	assign trial = {rem_q, nm_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nm_q  <= num[NW-1] ? NW'(-num) : NW'(num);
			neg_q <= num[NW-1];
			rem_q <= '0;
			den_q <= (den == '0) ? DW'(1) : den;   // zero divisor acts as one
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nm_q  <= {nm_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(nm_q) : $signed(nm_q);
endmodule

>>> rtl/lpps_sqrt.sv
// Digit-serial integer square root, one root bit per cycle.
module lpps_sqrt #(
	parameter int RW = lpps_pkg::RAD_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RW-1:0]   rad,
	output logic            done,
	output logic [RW/2-1:0] root
);
	localparam int QW    = RW / 2;
	localparam int CNT_W = $clog2(QW + 1);

	logic [RW-1:0]    rd_q;
	logic [QW:0]      rem_q;
	logic [QW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [QW+2:0]    rem_sh;
	logic [QW+2:0]    trial;
	logic             ge;
	logic [QW+2:0]    rem_sub;

	assign rem_sh  = {rem_q, rd_q[RW-1:RW-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign ge      = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rd_q   <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rd_q   <= {rd_q[RW-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[QW:0] : rem_sh[QW:0];
			root_q <= {root_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

>>> rtl/lpps_cordic.sv
// Iterative vectoring CORDIC: binary-angle atan2 of the leg difference, one step per cycle.
module lpps_cordic
	import lpps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIFF_W-1:0] dx,
	input  logic signed [DIFF_W-1:0] dy,
	output logic                     done,
	output logic [ANG_W-1:0]         angle
);
	logic signed [CORD_W-1:0] x_q, y_q;
	logic signed [CORD_W-1:0] x0, y0, sx, sy;
	logic [ANG_W-1:0]         ang_q;
	logic [3:0]               i_q;
	logic                     busy_q;
	logic                     done_q;

	assign x0 = $signed({{(CORD_W-DIFF_W){dx[DIFF_W-1]}}, dx}) <<< CORD_PRE;
	assign y0 = $signed({{(CORD_W-DIFF_W){dy[DIFF_W-1]}}, dy}) <<< CORD_PRE;
	assign sx = x_q >>> i_q;
	assign sy = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (dx == '0 && dy == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 4'(CORD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// left half plane: rotate by a half turn first
			if (x0 < 0) begin
				x_q   <= -x0;
				y_q   <= -y0;
				ang_q <= HALF_TURN;
			end else begin
				x_q   <= x0;
				y_q   <= y0;
				ang_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q   <= x_q + sy;
				y_q   <= y_q - sx;
				ang_q <= ang_q + atan_step(i_q);
			end else begin
				x_q   <= x_q - sy;
				y_q   <= y_q + sx;
				ang_q <= ang_q - atan_step(i_q);
			end
		end
	end

	assign done  = done_q;
	assign angle = ang_q;
endmodule

>>> rtl/leg_pair_pose_smoother.sv
// Top level: leg pair pose smoother with sequencer over serial arithmetic units.
//
// Usage notes
//  - Input channel in_valid/in_stall/in_item carries two leg positions, a velocity
//    and two visibility flags. An item is taken when in_valid is high and in_stall low.
//  - Output channel out_valid/out_stall/out_item returns one result item per input:
//    smoothed leftness, facing angle, separation mean and separation sigma.
//  - Config port: cfg_we writes cfg_data into register cfg_index; unknown indexes
//    are ignored. Write only while no item is in flight.
//  - One item at a time. The sequencer runs two serial multiplies, two serial
//    divides and a 14-step CORDIC (overlapped with the multiplies). With
//    separation update enabled and both legs seen, four more multiplies, two
//    divides and two serial square roots follow.
//  - in_stall is high from accept until the result is loaded into the output
//    register; the next item can be taken while that result waits.
//  - If the receiver stalls, the result holds in the output register and the
//    sequencer waits at its final step until the register frees up.
//  - Reset clears the handshake, loads register defaults and the smoothing
//    state (leftness 0, facing 0, mean MEAN_SEP, sigma SEP_SIGMA_INIT).
module leg_pair_pose_smoother #(
	parameter int MEAN_SEP       = lpps_pkg::MEAN_SEP_DEF,
	parameter int SEP_SIGMA_INIT = lpps_pkg::SIGMA_INIT_DEF,
	parameter int COORD_BITS     = lpps_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  lpps_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lpps_pkg::out_item_t               out_item,
	input  logic                              cfg_we,
	input  logic [lpps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpps_pkg::FIELD_W-1:0]      cfg_data
);
	import lpps_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_LA, ST_MUL_LB, ST_DIV_L, ST_DIV_F,
		ST_MUL_XX, ST_MUL_YY, ST_SQRT_C, ST_DIV_M,
		ST_MUL_S, ST_MUL_D, ST_DIV_S, ST_SQRT_S, ST_FIN
	} state_t;

	state_t state_q;

	// config registers
	logic [TC_W-1:0]  left_tc_q, face_tc_q, sep_tc_q, sigma_tc_q;
	logic [SEP_W-1:0] min_sep_q, max_sep_q;
	logic             sep_en_q;

	// smoothing state
	logic signed [LEFT_W-1:0] leftness_q;
	logic [ANG_W-1:0]         facing_q;
	logic [SEP_W-1:0]         mean_q;
	logic [SEP_W-1:0]         sigma_q;

	// per-item working registers
	logic signed [DIFF_W-1:0]  dx_q, dy_q;
	logic signed [COORD_W-1:0] vx_q, vy_q;
	logic                      both_seen_q;
	logic signed [PROD_W-1:0]  p1_q;
	logic signed [DIV_W-1:0]   dot_q;
	logic [RAD_W-1:0]          rad_q;
	logic [DIFF_W-1:0]         cursep_q;
	logic signed [DIFF_W:0]    d_q;
	logic [RAD_W-1:0]          s2_q, dd_q;
	logic                      pend_q;
	logic                      cor_rdy_q;

	out_item_t out_item_q;
	logic      out_valid_q;

	// unit hookup
	logic                     in_take;
	logic                     is_mul, is_div, is_sqrt, launch;
	logic                     mul_start, div_start, sqrt_start;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [DIV_W-1:0]  div_num;
	logic [TC_W-1:0]          div_den;
	logic [RAD_W-1:0]         sqrt_rad;
	logic                     mul_done, div_done, sqrt_done, cor_done;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [DIV_W-1:0]  div_q;
	logic [ROOT_W-1:0]        sqrt_root;
	logic [ANG_W-1:0]         cor_ang;

	logic signed [COORD_W-1:0] ax, ay, bx, by;
	logic signed [DIFF_W-1:0]  dx_in, dy_in;
	logic [ANG_W-1:0]          tgt0, tgt;
	logic [ANG_W-1:0]          fdiff;
	logic signed [DIV_W-1:0]   lsum, msum, s2sum;
	logic [DIFF_W-1:0]         m_raw;
	logic [SEP_W-1:0]          m_hi, m_clamp;

	assign in_take = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		ax    = coord_ext(in_item.leg_a_x, COORD_BITS);
		ay    = coord_ext(in_item.leg_a_y, COORD_BITS);
		bx    = coord_ext(in_item.leg_b_x, COORD_BITS);
		by    = coord_ext(in_item.leg_b_y, COORD_BITS);
		dx_in = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
		dy_in = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
	end

	assign is_mul  = (state_q == ST_MUL_LA) || (state_q == ST_MUL_LB) || (state_q == ST_MUL_XX)
		|| (state_q == ST_MUL_YY) || (state_q == ST_MUL_S) || (state_q == ST_MUL_D);
	assign is_div  = (state_q == ST_DIV_L) || (state_q == ST_DIV_F) || (state_q == ST_DIV_M)
		|| (state_q == ST_DIV_S);
	assign is_sqrt = (state_q == ST_SQRT_C) || (state_q == ST_SQRT_S);
	// facing divide needs the CORDIC angle
	assign launch  = !pend_q && (is_mul || is_div || is_sqrt)
		&& ((state_q != ST_DIV_F) || cor_rdy_q);
	assign mul_start  = launch && is_mul;
	assign div_start  = launch && is_div;
	assign sqrt_start = launch && is_sqrt;

	// facing target: atan2 plus a quarter turn, flipped a half turn when leftness is positive
	assign tgt0  = cor_ang + QUARTER_TURN;
	assign tgt   = (leftness_q > 0) ? tgt0 - HALF_TURN : tgt0;
	assign fdiff = tgt - facing_q;

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		div_num  = '0;
		div_den  = left_tc_q;
		sqrt_rad = rad_q;
		unique case (state_q)
			ST_MUL_LA: begin
				mul_a = MUL_W'(dx_q);
				mul_b = -MUL_W'(vy_q);
			end
			ST_MUL_LB: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(vx_q);
			end
			ST_MUL_XX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			ST_MUL_YY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			ST_MUL_S: begin
				mul_a = $signed({{(MUL_W-SEP_W){1'b0}}, sigma_q});
				mul_b = $signed({{(MUL_W-SEP_W){1'b0}}, sigma_q});
			end
			ST_MUL_D: begin
				mul_a = MUL_W'(d_q);
				mul_b = MUL_W'(d_q);
			end
			ST_DIV_L: begin
				div_num = dot_q - DIV_W'(leftness_q);
				div_den = left_tc_q;
			end
			ST_DIV_F: begin
				div_num = DIV_W'($signed(fdiff));
				div_den = face_tc_q;
			end
			ST_DIV_M: begin
				div_num = $signed({{(DIV_W-DIFF_W){1'b0}}, cursep_q})
					- $signed({{(DIV_W-SEP_W){1'b0}}, mean_q});
				div_den = sep_tc_q;
			end
			ST_DIV_S: begin
				div_num = $signed({{(DIV_W-RAD_W){1'b0}}, dd_q})
					- $signed({{(DIV_W-RAD_W){1'b0}}, s2_q});
				div_den = sigma_tc_q;
			end
			ST_SQRT_C: sqrt_rad = rad_q;
			ST_SQRT_S: sqrt_rad = s2_q;
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// update sums
	assign lsum  = DIV_W'(leftness_q) + div_q;
	assign msum  = $signed({{(DIV_W-SEP_W){1'b0}}, mean_q}) + div_q;
	assign s2sum = $signed({{(DIV_W-RAD_W){1'b0}}, s2_q}) + div_q;
	assign m_raw = msum[DIFF_W-1:0];
	// clamp to max first, then to min (min wins when bounds cross)
	assign m_hi    = (m_raw > {{(DIFF_W-SEP_W){1'b0}}, max_sep_q}) ? max_sep_q : m_raw[SEP_W-1:0];
	assign m_clamp = (m_hi < min_sep_q) ? min_sep_q : m_hi;

	lpps_mul #(.W(MUL_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	lpps_div #(.NW(DIV_W), .DW(TC_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_q)
	);

	lpps_sqrt #(.RW(RAD_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .rad(sqrt_rad),
		.done(sqrt_done), .root(sqrt_root)
	);

	lpps_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(in_take), .dx(dx_in), .dy(dy_in),
		.done(cor_done), .angle(cor_ang)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_tc_q  <= TC_W'(16);
			face_tc_q  <= TC_W'(16);
			sep_tc_q   <= TC_W'(16);
			sigma_tc_q <= TC_W'(16);
			min_sep_q  <= SEP_W'(100);
			max_sep_q  <= SEP_W'(600);
			sep_en_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_LEFT_TC:  left_tc_q  <= cfg_data[TC_W-1:0];
				REG_FACE_TC:  face_tc_q  <= cfg_data[TC_W-1:0];
				REG_SEP_TC:   sep_tc_q   <= cfg_data[TC_W-1:0];
				REG_SIGMA_TC: sigma_tc_q <= cfg_data[TC_W-1:0];
				REG_MIN_SEP:  min_sep_q  <= cfg_data;
				REG_MAX_SEP:  max_sep_q  <= cfg_data;
				REG_SEP_EN:   sep_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, smoothing state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			cor_rdy_q   <= 1'b0;
			out_valid_q <= 1'b0;
			leftness_q  <= '0;
			facing_q    <= '0;
			mean_q      <= SEP_W'(MEAN_SEP);
			sigma_q     <= SEP_W'(SEP_SIGMA_INIT);
		end else begin
			// the final step reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_FIN) out_valid_q <= 1'b0;
			if (launch) pend_q <= 1'b1;
			if (mul_done || div_done || sqrt_done) pend_q <= 1'b0;
			if (cor_done) cor_rdy_q <= 1'b1;

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						dx_q        <= dx_in;
						dy_q        <= dy_in;
						vx_q        <= coord_ext(in_item.vel_x, COORD_BITS);
						vy_q        <= coord_ext(in_item.vel_y, COORD_BITS);
						both_seen_q <= in_item.leg_a_seen && in_item.leg_b_seen;
						cor_rdy_q   <= 1'b0;
						state_q     <= ST_MUL_LA;
					end
				end
				ST_MUL_LA: if (mul_done) begin
					p1_q    <= mul_p;
					state_q <= ST_MUL_LB;
				end
				ST_MUL_LB: if (mul_done) begin
					dot_q   <= DIV_W'(p1_q) + DIV_W'(mul_p);
					state_q <= ST_DIV_L;
				end
				ST_DIV_L: if (div_done) begin
					// stays between old value and dot, so no overflow
					leftness_q <= lsum[LEFT_W-1:0];
					state_q    <= ST_DIV_F;
				end
				ST_DIV_F: if (div_done) begin
					facing_q <= facing_q + div_q[ANG_W-1:0];
					state_q  <= (sep_en_q && both_seen_q) ? ST_MUL_XX : ST_FIN;
				end
				ST_MUL_XX: if (mul_done) begin
					p1_q    <= mul_p;
					state_q <= ST_MUL_YY;
				end
				ST_MUL_YY: if (mul_done) begin
					rad_q   <= RAD_W'(p1_q) + RAD_W'(mul_p);
					state_q <= ST_SQRT_C;
				end
				ST_SQRT_C: if (sqrt_done) begin
					cursep_q <= sqrt_root[DIFF_W-1:0];
					state_q  <= ST_DIV_M;
				end
				ST_DIV_M: if (div_done) begin
					d_q     <= $signed({1'b0, cursep_q}) - $signed({3'b000, mean_q});
					mean_q  <= m_clamp;
					state_q <= ST_MUL_S;
				end
				ST_MUL_S: if (mul_done) begin
					s2_q    <= RAD_W'(mul_p);
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: if (mul_done) begin
					dd_q    <= RAD_W'(mul_p);
					state_q <= ST_DIV_S;
				end
				ST_DIV_S: if (div_done) begin
					s2_q    <= s2sum[RAD_W-1:0];
					state_q <= ST_SQRT_S;
				end
				ST_SQRT_S: if (sqrt_done) begin
					sigma_q <= (|sqrt_root[ROOT_W-1:SEP_W]) ? {SEP_W{1'b1}}
						: sqrt_root[SEP_W-1:0];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_item_q.leftness_out  <= leftness_q;
						out_item_q.facing_out    <= $signed(facing_q);
						out_item_q.sep_mean_out  <= mean_q;
						out_item_q.sep_sigma_out <= sigma_q;
						out_valid_q              <= 1'b1;
						state_q                  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// an accepted item makes the block busy in the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input accepted but block not busy");

	// shared units only finish an operation that the sequencer launched
	a_done_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done || sqrt_done) |-> pend_q)
		else $error("unit done without pending operation");

	// nothing outstanding while waiting for an item
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("operation pending in idle");

	// a result is loaded only from the final step
	a_load_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside final step");
endmodule
